/* rtl/contiguous_unit_allocator_core_defines.svh */
// Assertion macros for the contiguous unit allocator checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef CONTIGUOUS_UNIT_ALLOCATOR_CORE_DEFINES_SVH
`define CONTIGUOUS_UNIT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cau_pkg.sv */
// Shared types and constants for the contiguous unit allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package cau_pkg;

    // Default sizes of the map and the owner table
    localparam int MEM_UNITS_DEF  = 64;
    localparam int MAX_OWNERS_DEF = 16;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int OWNER_W  = 4;
    localparam int SIZE_W   = 7;
    localparam int STATUS_W = 3;
    localparam int START_W  = 6;
    localparam int NOWN_W   = 5;
    localparam int ACTU_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Register reset values
    localparam logic [NOWN_W-1:0] NUM_OWNERS_RST   = NOWN_W'(16);
    localparam logic [ACTU_W-1:0] ACTIVE_UNITS_RST = ACTU_W'(64);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OWNERS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_UNITS = CFG_IDX_W'(1);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_FIRST   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEST    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WORST   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_ALLOC    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ALREADY  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTALLOC = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOFIT    = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  req_size;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start_index;
    } out_item_t;

    // One memory unit as held in a cell
    typedef struct packed {
        logic               used;
        logic [OWNER_W-1:0] owner;
    } unit_t;

    // Control of the cell chain from the sequencer
    typedef struct packed {
        logic  shift;
        unit_t tail;
    } chain_ctl_t;

endpackage

`default_nettype wire

/* rtl/cau_cell.sv */
// One memory unit cell of the rotating unit map.
// Depends on cau_pkg for the unit type.
`default_nettype none

module cau_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift,
    input  wire cau_pkg::unit_t d_in,
    output cau_pkg::unit_t     q
);
    import cau_pkg::*;

    unit_t unit_reg;
    unit_t unit_next;

    // Take the neighbor's unit while the chain rotates, else hold
    always_comb
    begin
        unit_next = shift ? d_in : unit_reg;
    end

    // Reset marks the unit free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= '0;
        end
        else
        begin
            unit_reg <= unit_next;
        end
    end

    assign q = unit_reg;

endmodule

`default_nettype wire

/* rtl/cau_ctrl.sv */
// Sequencer of the allocator: request decode, free-run scan at the chain head,
// mark and release pass, owner flags, config registers and result register.
// Depends on cau_pkg.
`default_nettype none

module cau_ctrl #(
    parameter int MEM_UNITS  = cau_pkg::MEM_UNITS_DEF,
    parameter int MAX_OWNERS = cau_pkg::MAX_OWNERS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire cau_pkg::in_item_t              in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output cau_pkg::out_item_t                  out_item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cau_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cau_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire cau_pkg::unit_t                 head,
    output cau_pkg::chain_ctl_t                 chain
);
    import cau_pkg::*;

    localparam int POS_W  = $clog2(MEM_UNITS);
    localparam int LEN_W  = $clog2(MEM_UNITS + 1);
    localparam int CMP_W  = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
    localparam int OIDX_W = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MEM_UNITS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MARK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                 state_reg,    state_next;
    logic [POS_W-1:0]       pos_reg,      pos_next;
    in_item_t               item_reg,     item_next;
    logic [STATUS_W-1:0]    status_reg,   status_next;
    logic [POS_W-1:0]       run_start_reg, run_start_next;
    logic [LEN_W-1:0]       run_len_reg,  run_len_next;
    logic                   found_reg,    found_next;
    logic [POS_W-1:0]       sel_start_reg, sel_start_next;
    logic [LEN_W-1:0]       sel_len_reg,  sel_len_next;
    logic [MAX_OWNERS-1:0]  flags_reg,    flags_next;
    logic [NOWN_W-1:0]      num_owners_reg,   num_owners_next;
    logic [ACTU_W-1:0]      active_units_reg, active_units_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_item_reg,  out_item_next;

    logic [OIDX_W-1:0] in_oidx;
    logic [OIDX_W-1:0] item_oidx;
    logic              unknown;
    logic              last;
    logic              in_scope;
    logic              unit_free;
    logic              in_run;
    logic [LEN_W-1:0]  ext_len;
    logic [POS_W-1:0]  ext_start;
    logic              closing;
    logic [LEN_W-1:0]  cand_len;
    logic [POS_W-1:0]  cand_start;
    logic              cand_fits;
    logic              better;
    logic              take;
    logic              in_range;
    unit_t             tail;

    assign in_oidx   = OIDX_W'(in_item.owner);
    assign item_oidx = OIDX_W'(item_reg.owner);
    assign unknown   = (NOWN_W'(in_item.owner) >= num_owners_reg)
                    || (32'(in_item.owner) >= 32'(MAX_OWNERS));
    assign last      = (pos_reg == POS_LAST);

    // Free-run tracking on the unit now at the chain head
    assign in_scope  = CMP_W'(pos_reg) < CMP_W'(active_units_reg);
    assign unit_free = !head.used && in_scope;
    assign in_run    = (run_len_reg != '0);
    assign ext_len   = in_run ? (run_len_reg + LEN_W'(1)) : LEN_W'(1);
    assign ext_start = in_run ? run_start_reg : pos_reg;

    // A run closes on a blocked unit or at the end of the map
    always_comb
    begin
        closing    = 1'b0;
        cand_len   = run_len_reg;
        cand_start = run_start_reg;
        if (unit_free && last)
        begin
            closing    = 1'b1;
            cand_len   = ext_len;
            cand_start = ext_start;
        end
        else if (!unit_free && in_run)
        begin
            closing = 1'b1;
        end
    end

    assign cand_fits = closing && (CMP_W'(cand_len) >= CMP_W'(item_reg.req_size));

    // Selection rule per kind; ties keep the earlier run
    always_comb
    begin
        case (item_reg.kind)
            KIND_FIRST: better = !found_reg;
            KIND_BEST:  better = !found_reg || (cand_len < sel_len_reg);
            KIND_WORST: better = !found_reg || (cand_len > sel_len_reg);
            default:    better = 1'b0;
        endcase
    end

    assign take = (state_reg == S_SCAN) && cand_fits && better;

    // Unit lies in the chosen run's leading req_size units
    assign in_range = (pos_reg >= sel_start_reg)
                   && (CMP_W'(pos_reg - sel_start_reg) < CMP_W'(item_reg.req_size));

    // Write back the head unit into the chain tail
    always_comb
    begin
        tail = head;
        if (state_reg == S_MARK)
        begin
            if (item_reg.kind == KIND_RELEASE)
            begin
                if (head.used && (head.owner == item_reg.owner))
                begin
                    tail = '0;
                end
            end
            else if (in_range)
            begin
                tail.used  = 1'b1;
                tail.owner = item_reg.owner;
            end
        end
    end

    assign chain.shift = (state_reg inside {S_SCAN, S_MARK});
    assign chain.tail  = tail;

    // Sequencer, scan registers, flags, config and result register
    always_comb
    begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        item_next         = item_reg;
        status_next       = status_reg;
        run_start_next    = run_start_reg;
        run_len_next      = run_len_reg;
        found_next        = found_reg;
        sel_start_next    = sel_start_reg;
        sel_len_next      = sel_len_reg;
        flags_next        = flags_reg;
        num_owners_next   = num_owners_reg;
        active_units_next = active_units_reg;
        out_valid_next    = out_valid_reg;
        out_item_next     = out_item_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Config writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUM_OWNERS:   num_owners_next   = NOWN_W'(cfg_data);
                CFG_ACTIVE_UNITS: active_units_next = ACTU_W'(cfg_data);
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next      = in_item;
                    pos_next       = '0;
                    run_len_next   = '0;
                    run_start_next = '0;
                    found_next     = 1'b0;
                    sel_start_next = '0;
                    sel_len_next   = '0;
                    if (unknown)
                    begin
                        status_next = STAT_UNKNOWN;
                        state_next  = S_DONE;
                    end
                    else if (in_item.kind == KIND_RELEASE)
                    begin
                        if (!flags_reg[in_oidx])
                        begin
                            status_next = STAT_NOTALLOC;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            status_next = STAT_RELEASED;
                            state_next  = S_MARK;
                        end
                    end
                    else if (flags_reg[in_oidx])
                    begin
                        status_next = STAT_ALREADY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        status_next = STAT_ALLOC;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                run_len_next   = unit_free ? ext_len : '0;
                run_start_next = ext_start;
                if (take)
                begin
                    found_next     = 1'b1;
                    sel_start_next = cand_start;
                    sel_len_next   = cand_len;
                end
                pos_next = last ? '0 : (pos_reg + POS_W'(1));
                if (last)
                begin
                    if (found_reg || take)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        status_next = STAT_NOFIT;
                        state_next  = S_DONE;
                    end
                end
            end

            S_MARK:
            begin
                pos_next = last ? '0 : (pos_reg + POS_W'(1));
                if (last)
                begin
                    flags_next[item_oidx] = (item_reg.kind != KIND_RELEASE);
                    state_next            = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_item_next.status = status_reg;
                    out_item_next.start_index =
                        (status_reg == STAT_ALLOC) ? START_W'(sel_start_reg) : '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pos_reg          <= '0;
            run_len_reg      <= '0;
            found_reg        <= 1'b0;
            flags_reg        <= '0;
            num_owners_reg   <= NUM_OWNERS_RST;
            active_units_reg <= ACTIVE_UNITS_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pos_reg          <= pos_next;
            run_len_reg      <= run_len_next;
            found_reg        <= found_next;
            flags_reg        <= flags_next;
            num_owners_reg   <= num_owners_next;
            active_units_reg <= active_units_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        status_reg    <= status_next;
        run_start_reg <= run_start_next;
        sel_start_reg <= sel_start_next;
        sel_len_reg   <= sel_len_next;
        out_item_reg  <= out_item_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

/* rtl/contiguous_unit_allocator_core.sv */
// Contiguous unit allocator: top level with the rotating unit map and sequencer.
// Depends on cau_pkg, cau_cell and cau_ctrl.
//
// Usage:
//   in channel  (in_valid/in_ready/in_item): one request item, accepted only
//     while the block is idle; in_ready drops for the duration of the item.
//   out channel (out_valid/out_ready/out_item): one result item per request,
//     held in an output register until taken; the next request is accepted
//     while a result waits.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//     index 0 num_owners, index 1 active_units, other indexes ignored.
// Steps from accept to result:
//   allocation  one rotation of the cell chain to scan for free runs, then one
//               rotation to mark the chosen run,
//   release     one rotation clearing the owner's units,
//   no fit      scan rotation only; a rejected request skips both rotations.
// The map rotates one unit per cycle past cell 0 while scanning or marking;
// one item is in flight at a time. Reset frees all units, clears all owner flags
// and restores num_owners = 16, active_units = 64. A stalled receiver holds the
// result; a finished item waits in its final state until the output register frees.
`default_nettype none

module contiguous_unit_allocator_core #(
    parameter int MEM_UNITS  = cau_pkg::MEM_UNITS_DEF,
    parameter int MAX_OWNERS = cau_pkg::MAX_OWNERS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire cau_pkg::in_item_t              in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output cau_pkg::out_item_t                  out_item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cau_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cau_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cau_pkg::*;

    unit_t      cell_q [MEM_UNITS];
    chain_ctl_t chain;

    // Row of unit cells; each takes its right neighbor, the last takes the head write-back
    for (genvar i = 0; i < MEM_UNITS; i++)
    begin : g_cell
        unit_t d_in;
        if (i == MEM_UNITS - 1)
        begin : g_tail
            assign d_in = chain.tail;
        end
        else
        begin : g_mid
            assign d_in = cell_q[i + 1];
        end

        cau_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (chain.shift),
            .d_in  (d_in),
            .q     (cell_q[i])
        );
    end

    // Sequencer at the chain head
    cau_ctrl #(
        .MEM_UNITS  (MEM_UNITS),
        .MAX_OWNERS (MAX_OWNERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (cell_q[0]),
        .chain     (chain)
    );

endmodule

`default_nettype wire

/* rtl/cau_checker.sv */
// Port-level checker for the contiguous unit allocator, bound to the top level.
// Depends on cau_pkg and contiguous_unit_allocator_core_defines.svh.
`default_nettype none

`include "contiguous_unit_allocator_core_defines.svh"

module cau_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire cau_pkg::out_item_t             out_item
);
    import cau_pkg::*;

    // Hold a stalled result
    `CAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")

    // One item at a time: no new request right after an accept
    `CAU_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "request accepted while busy")

    // Start index is zero unless the run was allocated
    `CAU_ASSERT_NOW(a_start_zero, out_valid && (out_item.status != STAT_ALLOC), out_item.start_index == '0, "start index set on non-allocation")

    // Status stays within the defined codes
    `CAU_ASSERT_NOW(a_status_code, out_valid, out_item.status <= STAT_NOFIT, "undefined status code")

endmodule

bind contiguous_unit_allocator_core cau_checker u_cau_checker (.*);

`default_nettype wire
